[design/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Depends on nothing; each use names its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define TFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Invariant that holds at every edge out of reset.
`define TFL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

`endif

[design/tfl_pkg.sv]
// Types and constants of the two-tier free-list allocator.
// Used by the top level; depends on nothing.
`default_nettype none

package tfl_pkg;

    localparam int FIELD_W     = 32;
    localparam int SIZE_W      = 16;
    localparam int SCOUNT_W    = 11;
    localparam int OCAP_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CTR_W       = 32;

    localparam int SIZE_RST   = 64;
    localparam int SCOUNT_RST = 1024;
    localparam int OCAP_RST   = 128;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ACT_STATIC   = 2'd0,
        ACT_OVERFLOW = 2'd1,
        ACT_SYSTEM   = 2'd2
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE_ADDRESS      = 2'd0,
        CFG_OBJECT_SIZE       = 2'd1,
        CFG_STATIC_COUNT      = 2'd2,
        CFG_OVERFLOW_CAPACITY = 2'd3
    } cfg_index_t;

    // Where the granted address of a result comes from.
    typedef enum logic [1:0] {
        SRC_REG,
        SRC_STATIC_RAM,
        SRC_OVERFLOW_RAM
    } grant_src_t;

endpackage

`default_nettype wire

[design/two_tier_free_list_allocator_unit.sv]
// Top level of the two-tier free-list buffer pool allocator.
// Depends on tfl_pkg, tfl_ram and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Buffer pool allocator. Each item is a get or a put of a buffer address.
// A get takes the most recently returned static buffer, else the next
// untouched static buffer, else the top of the overflow stack, else it
// reports a fresh system allocation (granted_address 0, action 2). A put
// pushes a static-region address back on the static stack, any other
// address on the overflow stack while there is room, and otherwise
// releases it to the system. Inconsistent requests come back with error
// set and leave the state unchanged. An item is taken in every cycle
// (busy stays low); its result is on the result ports for one cycle,
// marked by done: the taking edge loads the input register, the next
// edge carries the item through the decision logic into the result
// register and the registered read port of the stack RAMs. The receiver
// cannot stall, so a result must be captured at the edge that ends its
// done cycle, two edges after the taking edge.
// Both stacks reset undefined and need no clearing pass: only pushed
// entries are ever popped. Write configuration only while no item is in
// flight; cfg_ready is always high.
module two_tier_free_list_allocator_unit
    import tfl_pkg::*;
#(
    parameter int STATIC_DEPTH   = 1024,
    parameter int OVERFLOW_DEPTH = 128,
    parameter int ADDR_WIDTH     = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // item channel
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   command,
    input  wire logic [FIELD_W-1:0]     buffer_address,
    // result channel
    output logic                        done,
    output logic      [FIELD_W-1:0]     granted_address,
    output logic      [1:0]             action,
    output logic                        error,
    output logic      [CTR_W-1:0]       outstanding,
    output logic      [CTR_W-1:0]       high_water,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // Stored addresses keep only the bits both the field and ADDR_WIDTH allow.
    localparam int AW  = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
    localparam int SCW = ($clog2(STATIC_DEPTH + 1) > SCOUNT_W) ?
                         $clog2(STATIC_DEPTH + 1) : SCOUNT_W;
    localparam int OCW = ($clog2(OVERFLOW_DEPTH + 1) > OCAP_W) ?
                         $clog2(OVERFLOW_DEPTH + 1) : OCAP_W;
    localparam int SAW = (STATIC_DEPTH > 1) ? $clog2(STATIC_DEPTH) : 1;
    localparam int OAW = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
    localparam int SPW = SIZE_W + SCW;
    localparam int CW  = (AW > SPW) ? AW : SPW;

    localparam logic [SCW-1:0]   STATIC_DEPTH_C   = SCW'(STATIC_DEPTH);
    localparam logic [OCW-1:0]   OVERFLOW_DEPTH_C = OCW'(OVERFLOW_DEPTH);
    localparam int               SCOUNT_EFF_RST   =
        (STATIC_DEPTH < SCOUNT_RST) ? STATIC_DEPTH : SCOUNT_RST;
    localparam logic [SPW-1:0]   SPAN_RST         = SPW'(SIZE_RST * SCOUNT_EFF_RST);
    localparam logic [CTR_W-1:0] CTR_MAX          = {CTR_W{1'b1}};

    // ---------------------------------------------------------------
    // Configuration registers, plus the region span and the untouched
    // pointer address that follow from them.
    // ---------------------------------------------------------------
    logic [AW-1:0]       base_reg,   base_next;
    logic [SIZE_W-1:0]   size_reg,   size_next;
    logic [SCOUNT_W-1:0] scount_reg, scount_next;
    logic [OCAP_W-1:0]   ocap_reg,   ocap_next;
    logic [SPW-1:0]      span_reg,   span_next;
    logic                cfg_wr;
    logic [SCW-1:0]      scount_eff_next;
    logic [SPW-1:0]      untouched_offset;
    logic [AW-1:0]       untouched_cfg_addr;

    // ---------------------------------------------------------------
    // Allocator state.
    // ---------------------------------------------------------------
    logic [SCW-1:0]   ret_count_reg,  ret_count_next;
    logic [SCW-1:0]   untouched_idx_reg, untouched_idx_next;
    logic [AW-1:0]    untouched_addr_reg, untouched_addr_next;
    logic [OCW-1:0]   ovf_count_reg,  ovf_count_next;
    logic [CTR_W-1:0] alloc_count_reg, alloc_count_next;
    logic [CTR_W-1:0] release_count_reg, release_count_next;
    logic [CTR_W-1:0] peak_reg, peak_next;

    // Input register.
    logic          in_valid_reg;
    logic          cmd_reg;
    logic [AW-1:0] addr_reg;

    // Result register.
    logic             done_reg;
    grant_src_t       src_reg,    src_next;
    logic [AW-1:0]    grant_reg,  grant_next;
    action_t          action_reg, action_next;
    logic             error_reg,  error_next;
    logic [CTR_W-1:0] outstanding_reg;

    // Decision helpers.
    logic [SCW-1:0]   scount_eff;
    logic [OCW-1:0]   ocap_eff;
    logic [SCW-1:0]   remaining;
    logic [SCW:0]     static_fill;
    logic [AW-1:0]    addr_off;
    logic             in_region;
    logic [CTR_W-1:0] alloc_inc;
    logic [CTR_W-1:0] outs_get;
    logic [SCW-1:0]   ret_dec;
    logic [OCW-1:0]   ovf_dec;

    // Stack RAM ports.
    logic           s_we, s_re;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [AW-1:0]  s_rdata;
    logic           o_we, o_re;
    logic [OAW-1:0] o_waddr, o_raddr;
    logic [AW-1:0]  o_rdata;

    logic [AW-1:0]  grant_value;

    // Take an item every cycle; take configuration at any time.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Apply a configuration write and work out the derived values from the
    // new settings, so an item right behind the write sees them.
    always_comb
    begin
        base_next   = base_reg;
        size_next   = size_reg;
        scount_next = scount_reg;
        ocap_next   = ocap_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_BASE_ADDRESS:      base_next   = cfg_data[AW-1:0];
                CFG_OBJECT_SIZE:       size_next   = cfg_data[SIZE_W-1:0];
                CFG_STATIC_COUNT:      scount_next = cfg_data[SCOUNT_W-1:0];
                CFG_OVERFLOW_CAPACITY: ocap_next   = cfg_data[OCAP_W-1:0];
                default:               base_next   = base_reg;
            endcase
        end
    end

    assign scount_eff_next    = (SCW'(scount_next) > STATIC_DEPTH_C) ?
                                STATIC_DEPTH_C : SCW'(scount_next);
    assign span_next          = SPW'(size_next) * SPW'(scount_eff_next);
    assign untouched_offset   = SPW'(untouched_idx_reg) * SPW'(size_next);
    assign untouched_cfg_addr = base_next + AW'(untouched_offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            size_reg   <= SIZE_W'(SIZE_RST);
            scount_reg <= SCOUNT_W'(SCOUNT_RST);
            ocap_reg   <= OCAP_W'(OCAP_RST);
            span_reg   <= SPAN_RST;
        end
        else if (cfg_wr)
        begin
            base_reg   <= base_next;
            size_reg   <= size_next;
            scount_reg <= scount_next;
            ocap_reg   <= ocap_next;
            span_reg   <= span_next;
        end
    end

    // Input register: hold the item for the decision cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg  <= command;
            addr_reg <= buffer_address[AW-1:0];
        end
    end

    // Decision helpers.
    assign scount_eff  = (SCW'(scount_reg) > STATIC_DEPTH_C) ? STATIC_DEPTH_C : SCW'(scount_reg);
    assign ocap_eff    = (OCW'(ocap_reg) > OVERFLOW_DEPTH_C) ? OVERFLOW_DEPTH_C : OCW'(ocap_reg);
    assign remaining   = (scount_eff > untouched_idx_reg) ? (scount_eff - untouched_idx_reg) : '0;
    assign static_fill = {1'b0, ret_count_reg} + {1'b0, remaining};
    assign addr_off    = addr_reg - base_reg;
    assign in_region   = (addr_reg >= base_reg) && (CW'(addr_off) < CW'(span_reg));
    assign alloc_inc   = (alloc_count_reg == CTR_MAX) ? alloc_count_reg : alloc_count_reg + 1'b1;
    assign outs_get    = alloc_inc - release_count_reg;
    assign ret_dec     = ret_count_reg - 1'b1;
    assign ovf_dec     = ovf_count_reg - 1'b1;

    // One get or put: at most one stack push or pop plus counter updates.
    always_comb
    begin
        ret_count_next      = ret_count_reg;
        untouched_idx_next  = untouched_idx_reg;
        untouched_addr_next = untouched_addr_reg;
        ovf_count_next      = ovf_count_reg;
        alloc_count_next    = alloc_count_reg;
        release_count_next  = release_count_reg;
        peak_next           = peak_reg;
        src_next            = SRC_REG;
        grant_next          = '0;
        action_next         = ACT_STATIC;
        error_next          = 1'b0;
        s_we                = 1'b0;
        s_re                = 1'b0;
        o_we                = 1'b0;
        o_re                = 1'b0;

        if (in_valid_reg)
        begin
            if (cmd_reg == CMD_GET)
            begin
                if (ret_count_reg != '0)
                begin
                    ret_count_next = ret_dec;
                    s_re           = 1'b1;
                    src_next       = SRC_STATIC_RAM;
                end
                else if (untouched_idx_reg < scount_eff)
                begin
                    grant_next          = untouched_addr_reg;
                    untouched_idx_next  = untouched_idx_reg + 1'b1;
                    untouched_addr_next = untouched_addr_reg + AW'(size_reg);
                end
                else if (ovf_count_reg != '0)
                begin
                    ovf_count_next = ovf_dec;
                    o_re           = 1'b1;
                    src_next       = SRC_OVERFLOW_RAM;
                    action_next    = ACT_OVERFLOW;
                end
                else
                begin
                    alloc_count_next = alloc_inc;
                    if (outs_get > peak_reg)
                    begin
                        peak_next = outs_get;
                    end
                    action_next = ACT_SYSTEM;
                end
            end
            else if (in_region)
            begin
                action_next = ACT_STATIC;
                if ((static_fill >= {1'b0, scount_eff}) || (ret_count_reg >= STATIC_DEPTH_C))
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    s_we           = 1'b1;
                    ret_count_next = ret_count_reg + 1'b1;
                end
            end
            else if (ovf_count_reg < ocap_eff)
            begin
                action_next = ACT_OVERFLOW;
                if (alloc_count_reg == '0)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    o_we           = 1'b1;
                    ovf_count_next = ovf_count_reg + 1'b1;
                end
            end
            else
            begin
                action_next = ACT_SYSTEM;
                if (release_count_reg >= alloc_count_reg)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    release_count_next = release_count_reg + 1'b1;
                end
            end
        end
    end

    // Stack addresses: counts stay below the depth where they index.
    assign s_waddr = ret_count_reg[SAW-1:0];
    assign s_raddr = ret_dec[SAW-1:0];
    assign o_waddr = ovf_count_reg[OAW-1:0];
    assign o_raddr = ovf_dec[OAW-1:0];

    tfl_ram #(
        .WIDTH (AW),
        .DEPTH (STATIC_DEPTH)
    ) u_static_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (addr_reg),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    tfl_ram #(
        .WIDTH (AW),
        .DEPTH (OVERFLOW_DEPTH)
    ) u_overflow_stack (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (addr_reg),
        .re    (o_re),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    // Advance allocator state; a configuration write rebuilds the pointer
    // address from the new base and size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ret_count_reg      <= '0;
            untouched_idx_reg  <= '0;
            untouched_addr_reg <= '0;
            ovf_count_reg      <= '0;
            alloc_count_reg    <= '0;
            release_count_reg  <= '0;
            peak_reg           <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            ret_count_reg      <= ret_count_next;
            untouched_idx_reg  <= untouched_idx_next;
            untouched_addr_reg <= cfg_wr ? untouched_cfg_addr : untouched_addr_next;
            ovf_count_reg      <= ovf_count_next;
            alloc_count_reg    <= alloc_count_next;
            release_count_reg  <= release_count_next;
            peak_reg           <= peak_next;
            done_reg           <= in_valid_reg;
        end
    end

    // Result register; popped addresses arrive from the RAM read ports.
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            src_reg         <= src_next;
            grant_reg       <= grant_next;
            action_reg      <= action_next;
            error_reg       <= error_next;
            outstanding_reg <= alloc_count_next - release_count_next;
        end
    end

    always_comb
    begin
        case (src_reg)
            SRC_STATIC_RAM:   grant_value = s_rdata;
            SRC_OVERFLOW_RAM: grant_value = o_rdata;
            default:          grant_value = grant_reg;
        endcase
    end

    assign done            = done_reg;
    assign granted_address = FIELD_W'(grant_value);
    assign action          = action_reg;
    assign error           = error_reg;
    assign outstanding     = outstanding_reg;
    assign high_water      = peak_reg;

    // Every accepted item gives a result in the cycle after its decision.
    `TFL_ASSERT_NEXT(a_item_gives_result, clk, rst_n, in_valid_reg, done_reg)
    // A dropped request never hands out an address.
    `TFL_ASSERT_IMP(a_error_no_grant, clk, rst_n, done_reg && error_reg, granted_address == '0)
    // The peak never trails the current outstanding count.
    `TFL_ASSERT_IMP(a_peak_covers, clk, rst_n, done_reg, high_water >= outstanding)
    // Stack fill stays within the RAMs.
    `TFL_ASSERT_ALWAYS(a_static_bound, clk, rst_n, ret_count_reg <= STATIC_DEPTH_C)
    `TFL_ASSERT_ALWAYS(a_overflow_bound, clk, rst_n, ovf_count_reg <= OVERFLOW_DEPTH_C)

endmodule

`default_nettype wire

[design/tfl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module tfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
